### sv/i8dp_pkg.sv
// Shared types and constants for the int8 dot product dequantizer.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package i8dp_pkg;

	localparam int LANES      = 4;
	localparam int ACT_W      = 8;
	localparam int PROD_W     = 2 * ACT_W;
	localparam int LANE_CNT_W = 3;
	localparam int SUM_W      = 32;
	localparam int SCALE_W    = 32;
	localparam int BIAS_W     = 32;
	localparam int MUL_W      = SUM_W + SCALE_W;
	localparam int RES_W      = 48;

	// One input transaction
	typedef struct packed {
		logic signed [ACT_W-1:0]      act_0;
		logic signed [ACT_W-1:0]      act_1;
		logic signed [ACT_W-1:0]      act_2;
		logic signed [ACT_W-1:0]      act_3;
		logic signed [ACT_W-1:0]      wgt_0;
		logic signed [ACT_W-1:0]      wgt_1;
		logic signed [ACT_W-1:0]      wgt_2;
		logic signed [ACT_W-1:0]      wgt_3;
		logic        [LANE_CNT_W-1:0] lanes_used;
		logic                         last_pair;
		logic        [SCALE_W-1:0]    row_scale;
		logic signed [BIAS_W-1:0]     column_bias;
	} item_t;

	// One output transaction
	typedef struct packed {
		logic signed [RES_W-1:0] result_value;
		logic signed [SUM_W-1:0] dot_sum;
	} result_t;

	// Finished dot sum handed from the merge stage to the scaling stages
	typedef struct packed {
		logic                     valid;
		logic signed [SUM_W-1:0]  dot;
		logic [SCALE_W-1:0]       scale;
		logic signed [BIAS_W-1:0] bias;
	} scl_req_t;

endpackage

### sv/i8dp_lane.sv
// One multiply lane: signed 8x8 product of an activation/weight pair.
// Depends on i8dp_pkg.
`timescale 1ns / 1ps

module i8dp_lane (
	input  logic                              clk,
	input  logic                              advance,
	input  logic                              en,
	input  logic signed [i8dp_pkg::ACT_W-1:0] act,
	input  logic signed [i8dp_pkg::ACT_W-1:0] wgt,
	output logic signed [i8dp_pkg::PROD_W-1:0] product_s1
);
	import i8dp_pkg::*;

	logic signed [PROD_W-1:0] prod_c;

	// Multiply at full product width
	assign prod_c = PROD_W'(act) * PROD_W'(wgt);

	// Register the product; a lane beyond the count contributes zero
	always_ff @(posedge clk) begin
		if (advance) begin
			product_s1 <= en ? prod_c : '0;
		end
	end

endmodule

### sv/i8dp_merge.sv
// Merge stage: adds the lane products into the running sum and hands the
// finished sum of a run on to scaling. Depends on i8dp_pkg.
`timescale 1ns / 1ps

module i8dp_merge (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    advance,
	input  logic                                    accept,
	input  logic                                    last_pair,
	input  logic [i8dp_pkg::SCALE_W-1:0]            row_scale,
	input  logic signed [i8dp_pkg::BIAS_W-1:0]      column_bias,
	input  logic signed [i8dp_pkg::PROD_W-1:0]      product_s1 [i8dp_pkg::LANES],
	output i8dp_pkg::scl_req_t                      req_s2
);
	import i8dp_pkg::*;

	logic                     valid_s1;
	logic                     last_s1;
	logic [SCALE_W-1:0]       scale_s1;
	logic signed [BIAS_W-1:0] bias_s1;
	logic [SUM_W-1:0]         running_q;
	logic [SUM_W-1:0]         sum_c;
	logic                     valid_s2;
	logic signed [SUM_W-1:0]  dot_s2;
	logic [SCALE_W-1:0]       scale_s2;
	logic signed [BIAS_W-1:0] bias_s2;

	// Add all lanes onto the running sum, wrapping at 32 bits
	always_comb begin
		sum_c = running_q;
		for (int i = 0; i < LANES; i++) begin
			sum_c = sum_c + SUM_W'(product_s1[i]);
		end
	end

	// Control: stage valids and the accumulator, cleared after each last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			running_q <= '0;
		end else if (advance) begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1 && last_s1;
			if (valid_s1) begin
				running_q <= last_s1 ? '0 : sum_c;
			end
		end
	end

	// Payload: carry scale and bias alongside, capture the finished sum
	always_ff @(posedge clk) begin
		if (advance) begin
			last_s1  <= last_pair;
			scale_s1 <= row_scale;
			bias_s1  <= column_bias;
			dot_s2   <= sum_c;
			scale_s2 <= scale_s1;
			bias_s2  <= bias_s1;
		end
	end

	assign req_s2.valid = valid_s2;
	assign req_s2.dot   = dot_s2;
	assign req_s2.scale = scale_s2;
	assign req_s2.bias  = bias_s2;

endmodule

### sv/i8dp_scale.sv
// Dequantise: dot sum times unsigned Q16.16 scale, plus signed Q16.16 bias,
// saturated to 48 bits, into the output register. Depends on i8dp_pkg.
`timescale 1ns / 1ps

module i8dp_scale (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  i8dp_pkg::scl_req_t req_s2,
	output logic               result_valid,
	output i8dp_pkg::result_t  result
);
	import i8dp_pkg::*;

	logic signed [SUM_W:0]        dot_x;
	logic signed [SCALE_W:0]      scale_x;
	logic signed [2*SUM_W+1:0]    full_c;
	logic                         valid_s3;
	logic signed [MUL_W-1:0]      prod_s3;
	logic signed [BIAS_W-1:0]     bias_s3;
	logic signed [SUM_W-1:0]      dot_s3;
	logic signed [MUL_W:0]        total_c;
	logic                         ovf_c;
	logic signed [RES_W-1:0]      sat_c;
	logic                         valid_q;
	result_t                      result_q;

	// Signed by unsigned multiply; the exact product fits in 64 bits
	assign dot_x   = {req_s2.dot[SUM_W-1], req_s2.dot};
	assign scale_x = {1'b0, req_s2.scale};
	assign full_c  = dot_x * scale_x;

	// Add the bias with one guard bit, then clamp to the 48-bit range
	assign total_c = {prod_s3[MUL_W-1], prod_s3} + (MUL_W+1)'(bias_s3);
	assign ovf_c   = (total_c[MUL_W:RES_W-1] != '0) && (total_c[MUL_W:RES_W-1] != '1);
	always_comb begin
		if (!ovf_c) begin
			sat_c = total_c[RES_W-1:0];
		end else if (total_c[MUL_W]) begin
			sat_c = {1'b1, {(RES_W-1){1'b0}}};
		end else begin
			sat_c = {1'b0, {(RES_W-1){1'b1}}};
		end
	end

	// Valid bits of the multiply stage and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_q  <= 1'b0;
		end else if (advance) begin
			valid_s3 <= req_s2.valid;
			valid_q  <= valid_s3;
		end
	end

	// Payload of both stages; hold while the output is stalled
	always_ff @(posedge clk) begin
		if (advance) begin
			prod_s3               <= full_c[MUL_W-1:0];
			bias_s3               <= req_s2.bias;
			dot_s3                <= req_s2.dot;
			result_q.result_value <= sat_c;
			result_q.dot_sum      <= dot_s3;
		end
	end

	assign result_valid = valid_q;
	assign result       = result_q;

endmodule

### sv/int8_dot_product_dequantizer.sv
// Int8 dot product with dequantisation: one group of up to four signed 8-bit
// activation/weight pairs enters per cycle while the output is not stalled
// and is multiplied in four lanes; a merge stage adds the lane products into
// a 32-bit running sum. On a group marked last the sum is multiplied by the
// Q16.16 row scale, the Q16.16 column bias is added and the result saturated
// to 48 bits. The sustained rate is set by the accumulate loop in the merge
// stage. A finished run passes the lane, merge, multiply and output registers
// in turn. A stall on the output freezes the whole pipeline, so the input
// stall is raised only while a finished result waits to be taken.
// Depends on i8dp_pkg, i8dp_lane, i8dp_merge and i8dp_scale.
`timescale 1ns / 1ps

module int8_dot_product_dequantizer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  i8dp_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output i8dp_pkg::result_t result
);
	import i8dp_pkg::*;

	logic                     advance;
	logic                     accept;
	logic signed [ACT_W-1:0]  act_a [LANES];
	logic signed [ACT_W-1:0]  wgt_a [LANES];
	logic                     en_a  [LANES];
	logic signed [PROD_W-1:0] product_s1 [LANES];
	scl_req_t                 req_s2;

	// Advance the pipeline unless a result is waiting and stalled
	assign advance    = !result_valid || !result_stall;
	assign item_stall = !advance;
	assign accept     = item_valid && advance;

	// Spread the transaction across the lanes
	assign act_a[0] = item.act_0;
	assign act_a[1] = item.act_1;
	assign act_a[2] = item.act_2;
	assign act_a[3] = item.act_3;
	assign wgt_a[0] = item.wgt_0;
	assign wgt_a[1] = item.wgt_1;
	assign wgt_a[2] = item.wgt_2;
	assign wgt_a[3] = item.wgt_3;

	// Enable lanes below the count; counts above the lane total enable all
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			en_a[i] = item.lanes_used > LANE_CNT_W'(i);
		end
	end

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		i8dp_lane u_lane (
			.clk        (clk),
			.advance    (advance),
			.en         (en_a[g]),
			.act        (act_a[g]),
			.wgt        (wgt_a[g]),
			.product_s1 (product_s1[g])
		);
	end

	i8dp_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.accept      (accept),
		.last_pair   (item.last_pair),
		.row_scale   (item.row_scale),
		.column_bias (item.column_bias),
		.product_s1  (product_s1),
		.req_s2      (req_s2)
	);

	i8dp_scale u_scale (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.req_s2       (req_s2),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule
